/* sv/lkvc_pkg.sv */
package lkvc_pkg;

    // Field widths fixed by the transaction format
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int ACT_W = 2;
    localparam int CAP_W = 7;

    // Default store depth and capacity after reset
    localparam int ENTRIES_DEF = 64;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // Value returned by a get that misses
    localparam logic signed [VAL_W-1:0] MISS_VALUE = -32'sd1;

    // Request codes
    localparam logic [ACT_W-1:0] ACT_GET   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_PUT   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_PROBE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_NONE  = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0]        action;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic                    hit;
        logic signed [VAL_W-1:0] read_value;
        logic                    evicted;
        logic signed [KEY_W-1:0] evicted_key;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_AGE,
        ST_WRITE,
        ST_DONE
    } state_t;

endpackage

/* sv/lru_key_value_cache_top.sv */
// Sequence: a get hit or a put scans for the key (SCAN), decides (DECIDE), re-ages
// the entries (AGE), writes (WRITE) and raises done (DONE); a get miss or probe ends
// after DECIDE, an ignored code goes straight to DONE; an empty store skips the scan.
// Throughput: one transaction at a time, the next is taken the cycle after done; key and
// age memories are scanned one entry per cycle, once to match and once to re-age.
// Reset empties the store (fill count to zero), sets capacity to 64; no receiver stall.
module lru_key_value_cache_top #(
    parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  lkvc_pkg::req_t              req,
    output logic                        done,
    output lkvc_pkg::rsp_t              rsp,
    input  logic                        cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0]  cfg_wdata
);

    import lkvc_pkg::*;

    localparam int IW    = $clog2(ENTRIES);
    localparam int CW    = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CW > CAP_W) ? CW : CAP_W;

    state_t state_reg, state_next;

    // Control state
    logic [CAP_W-1:0] cap_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    idx_reg;
    logic             pend_reg;
    logic             found_reg;
    logic             evict_reg;
    logic             ins_reg;

    // Held transaction and scan results
    logic [ACT_W-1:0]        act_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic signed [VAL_W-1:0] val_reg;
    logic [IW-1:0]           pidx_reg;
    logic [IW-1:0]           match_idx_reg;
    logic [IW-1:0]           match_age_reg;
    logic [IW-1:0]           old_idx_reg;
    logic signed [KEY_W-1:0] evk_reg;
    logic [IW-1:0]           tgt_reg;

    // Memory ports
    logic              rd_en;
    logic              key_re, key_we;
    logic              age_re, age_we;
    logic              val_re, val_we;
    logic [KEY_W-1:0]  key_rdata;
    logic [VAL_W-1:0]  val_rdata;
    logic [IW-1:0]     age_rdata;
    logic [IW-1:0]     age_waddr;
    logic [IW-1:0]     age_wdata;
    logic [IW-1:0]     age_aged;
    logic [IW-1:0]     oldest_age;
    logic [CMP_W-1:0]  cap_eff;
    logic              full;
    logic              accept;

    assign accept = start && (state_reg == ST_IDLE);

    // Clamp capacity into 1 .. ENTRIES
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CMP_W'(1);
        end
        else if (CMP_W'(cap_reg) > CMP_W'(ENTRIES))
        begin
            cap_eff = CMP_W'(ENTRIES);
        end
        else
        begin
            cap_eff = CMP_W'(cap_reg);
        end
    end

    assign full       = CMP_W'(count_reg) >= cap_eff;
    assign oldest_age = IW'(count_reg - CW'(1));

    // Age update: insert ages every entry, touch ages those younger than the hit
    assign age_aged = (!found_reg || (age_rdata < match_age_reg))
                      ? age_rdata + IW'(1) : age_rdata;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (req.action == ACT_NONE)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = ST_DECIDE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if ((idx_reg == count_reg) && !pend_reg)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                case (act_reg)
                    ACT_GET:   state_next = found_reg ? ST_AGE : ST_DONE;
                    ACT_PUT:   state_next = ST_AGE;
                    default:   state_next = ST_DONE;
                endcase
            end
            ST_AGE:
            begin
                if ((idx_reg == count_reg) && !pend_reg)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        busy      = (state_reg != ST_IDLE);
        done      = (state_reg == ST_DONE);
        rd_en     = 1'b0;
        key_re    = 1'b0;
        age_re    = 1'b0;
        age_we    = 1'b0;
        age_waddr = pidx_reg;
        age_wdata = age_aged;
        key_we    = 1'b0;
        val_we    = 1'b0;
        val_re    = 1'b0;
        case (state_reg)
            ST_SCAN:
            begin
                rd_en  = (idx_reg < count_reg);
                key_re = rd_en;
                age_re = rd_en;
            end
            ST_DECIDE:
            begin
                val_re = 1'b1;
            end
            ST_AGE:
            begin
                rd_en  = (idx_reg < count_reg);
                age_re = rd_en;
                age_we = pend_reg;
            end
            ST_WRITE:
            begin
                age_we    = 1'b1;
                age_waddr = tgt_reg;
                age_wdata = '0;
                key_we    = ins_reg;
                val_we    = (act_reg == ACT_PUT);
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cap_reg   <= CAP_RESET;
            count_reg <= '0;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
            evict_reg <= 1'b0;
            ins_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    idx_reg  <= '0;
                    pend_reg <= 1'b0;
                    if (accept)
                    begin
                        found_reg <= 1'b0;
                        evict_reg <= 1'b0;
                        ins_reg   <= 1'b0;
                    end
                end
                ST_SCAN:
                begin
                    // advance the read pointer, compare returning data
                    idx_reg  <= idx_reg + CW'(rd_en);
                    pend_reg <= rd_en;
                    if (pend_reg && (key_rdata == key_reg))
                    begin
                        found_reg <= 1'b1;
                    end
                end
                ST_DECIDE:
                begin
                    idx_reg  <= '0;
                    pend_reg <= 1'b0;
                    if ((act_reg == ACT_PUT) && !found_reg)
                    begin
                        ins_reg   <= 1'b1;
                        evict_reg <= full;
                    end
                end
                ST_AGE:
                begin
                    idx_reg  <= idx_reg + CW'(rd_en);
                    pend_reg <= rd_en;
                end
                ST_WRITE:
                begin
                    // grow the fill count on insert without eviction
                    if (ins_reg && !evict_reg)
                    begin
                        count_reg <= count_reg + CW'(1);
                    end
                end
                default:
                begin
                    pend_reg <= 1'b0;
                end
            endcase
        end
    end

    // Transaction and scan payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg <= req.action;
            key_reg <= req.key;
            val_reg <= req.value;
        end
        pidx_reg <= idx_reg[IW-1:0];
        if ((state_reg == ST_SCAN) && pend_reg)
        begin
            if (key_rdata == key_reg)
            begin
                match_idx_reg <= pidx_reg;
                match_age_reg <= age_rdata;
            end
            if (age_rdata == oldest_age)
            begin
                old_idx_reg <= pidx_reg;
                evk_reg     <= key_rdata;
            end
        end
        if (state_reg == ST_DECIDE)
        begin
            if (found_reg)
            begin
                tgt_reg <= match_idx_reg;
            end
            else if (full)
            begin
                tgt_reg <= old_idx_reg;
            end
            else
            begin
                tgt_reg <= count_reg[IW-1:0];
            end
        end
    end

    // Result fields
    always_comb
    begin
        rsp.hit         = found_reg;
        rsp.read_value  = '0;
        rsp.evicted     = evict_reg;
        rsp.evicted_key = evict_reg ? evk_reg : '0;
        if (act_reg == ACT_GET)
        begin
            rsp.read_value = found_reg ? val_rdata : MISS_VALUE;
        end
    end

    lkvc_ram #(
        .WIDTH (KEY_W),
        .DEPTH (ENTRIES)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (tgt_reg),
        .wdata (key_reg),
        .re    (key_re),
        .raddr (idx_reg[IW-1:0]),
        .rdata (key_rdata)
    );

    lkvc_ram #(
        .WIDTH (VAL_W),
        .DEPTH (ENTRIES)
    ) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (tgt_reg),
        .wdata (val_reg),
        .re    (val_re),
        .raddr (match_idx_reg),
        .rdata (val_rdata)
    );

    lkvc_ram #(
        .WIDTH (IW),
        .DEPTH (ENTRIES)
    ) u_age_ram (
        .clk   (clk),
        .we    (age_we),
        .waddr (age_waddr),
        .wdata (age_wdata),
        .re    (age_re),
        .raddr (idx_reg[IW-1:0]),
        .rdata (age_rdata)
    );

endmodule

/* sv/lkvc_ram.sv */
module lkvc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds its data between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/lkvc_checker.sv */
module lkvc_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           busy,
    input  logic           done,
    input  lkvc_pkg::rsp_t rsp
);

    import lkvc_pkg::*;

    // An accepted transaction keeps the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // Result only while busy, and the block frees right after it
    a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy ##1 !busy)
        else $error("result outside a transaction or block held busy");

    // An eviction only happens on a put that missed
    a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.evicted) |-> !rsp.hit)
        else $error("eviction reported on a hit");

    // No eviction, no evicted key
    a_evict_key: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !rsp.evicted) |-> (rsp.evicted_key == '0))
        else $error("evicted key without eviction");

endmodule

bind lru_key_value_cache_top lkvc_checker u_lkvc_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);
